[rtl/core/sss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

    // fixed field widths of the request and response
    localparam int CMD_W   = 2;
    localparam int VALUE_W = 8;
    localparam int SUM_W   = 12;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [SUM_W-1:0]   t_sum;

    // request command codes
    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_ADD   = 2'd1;
    localparam t_cmd CMD_FETCH = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic clear;
        logic add_noop;
        logic add_prime;
        logic add_step;
        logic fetch_start;
        logic fetch_step;
        logic res_ok;
        logic res_rej;
        logic put;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic ws_out;
        logic d_zero;
        logic cur_out;
        logic hit;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/core/sss_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

// request channel: command and value
interface sss_req_if;
    import sss_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   command;
    t_value value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// response channel: one result per request
interface sss_rsp_if;
    import sss_pkg::*;

    logic valid;
    logic ready;
    t_sum sum;
    logic sum_valid;
    logic accepted;

    modport source (output valid, output sum, output sum_valid, output accepted, input ready);
    modport sink   (input valid, input sum, input sum_valid, input accepted, output ready);
endinterface

`default_nettype wire

[rtl/core/sss_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module sss_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire sss_pkg::t_cmd     i_command,
    output logic                   o_req_ready,
    output sss_pkg::t_dp_cmd       o_cmd,
    input  wire sss_pkg::t_dp_stat i_stat
);
    import sss_pkg::*;

    typedef enum logic [8:0] {
        S_INIT       = 9'b000000001,
        S_IDLE       = 9'b000000010,
        S_CLEAR      = 9'b000000100,
        S_ADD_CHK    = 9'b000001000,
        S_ADD_RUN    = 9'b000010000,
        S_ADD_DRAIN  = 9'b000100000,
        S_FETCH_RD   = 9'b001000000,
        S_FETCH_SCAN = 9'b010000000,
        S_PUT        = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_command)
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_ADD:   n_state = S_ADD_CHK;
                        CMD_FETCH: n_state = S_FETCH_RD;
                        default: begin
                            o_cmd.res_rej = 1'b1;
                            n_state       = S_PUT;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clear  = 1'b1;
                o_cmd.res_ok = 1'b1;
                n_state      = S_PUT;
            end
            S_ADD_CHK: begin
                if (i_stat.full) begin
                    o_cmd.res_rej = 1'b1;
                    n_state       = S_PUT;
                end else if (i_stat.ws_out) begin
                    o_cmd.add_noop = 1'b1;
                    o_cmd.res_ok   = 1'b1;
                    n_state        = S_PUT;
                end else begin
                    o_cmd.add_prime = 1'b1;
                    o_cmd.res_ok    = 1'b1;
                    n_state         = S_ADD_RUN;
                end
            end
            S_ADD_RUN: begin
                o_cmd.add_step = 1'b1;
                if (i_stat.d_zero) begin
                    n_state = S_ADD_DRAIN;
                end
            end
            S_ADD_DRAIN: begin
                n_state = S_PUT;
            end
            S_FETCH_RD: begin
                if (i_stat.cur_out) begin
                    o_cmd.res_ok = 1'b1;
                    n_state      = S_PUT;
                end else begin
                    o_cmd.fetch_start = 1'b1;
                    n_state           = S_FETCH_SCAN;
                end
            end
            S_FETCH_SCAN: begin
                o_cmd.fetch_step = 1'b1;
                if (i_stat.hit || i_stat.scan_last) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_stat.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sss_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module sss_dp #(
    parameter int MAX_ITEMS  = 16,
    parameter int VALUE_BITS = 8,
    parameter int MAP_WORDS  = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sss_pkg::t_value  i_value,
    input  wire sss_pkg::t_dp_cmd i_cmd,
    output sss_pkg::t_dp_stat     o_stat,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output sss_pkg::t_sum         o_sum,
    output logic                  o_sum_valid,
    output logic                  o_accepted
);
    import sss_pkg::*;

    localparam int WA = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int XW = WA + 3;
    localparam int CW = $clog2(MAP_WORDS * WORD_W + 1);
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam logic [XW-1:0] LAST_W = XW'(MAP_WORDS - 1);
    localparam logic [VALUE_W-1:0] VAL_MASK =
        (VALUE_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((1 << VALUE_BITS) - 1);

    // bitmap storage
    logic [WORD_W-1:0] mem [MAP_WORDS];

    logic [VALUE_W-1:0] r_val;
    logic [NW-1:0]      r_count;
    logic [CW-1:0]      r_cursor;
    logic [WA-1:0]      r_top;
    logic [WA-1:0]      r_lim;
    logic [WA-1:0]      r_d;
    logic [WA-1:0]      r_wd;
    logic               r_pend;
    logic               r_prime;
    logic [WORD_W-1:0]  r_rd0;
    logic [WORD_W-1:0]  r_rd1;
    logic               r_ok0;
    logic               r_ok1;
    logic [WORD_W-1:0]  r_src_hi;
    logic [WA-1:0]      r_rd_word;
    logic [BIT_W-1:0]   r_off;
    logic               r_first;
    t_sum               r_res_sum;
    logic               r_res_sv;
    logic               r_res_acc;
    logic               r_o_vld;
    t_sum               r_o_sum;
    logic               r_o_sv;
    logic               r_o_acc;

    logic [XW-1:0]      ws;
    logic [BIT_W-1:0]   bs;
    logic [XW-1:0]      top_x;
    logic [XW-1:0]      lim_x;
    logic [XW-1:0]      d_x;
    logic [XW-1:0]      grow;
    logic [WA-1:0]      new_top;
    logic [XW-1:0]      prime_idx_x;
    logic [XW-1:0]      lo_idx_x;
    logic [XW-1:0]      cur_word_x;
    logic [WA-1:0]      a0;
    logic [WA-1:0]      a1;
    logic               n_ok0;
    logic               n_ok1;
    logic [WORD_W-1:0]  m0;
    logic [WORD_W-1:0]  m1;
    logic [WORD_W-1:0]  carry_in;
    logic [WORD_W-1:0]  add_wdata;
    logic               mem_we;
    logic [WA-1:0]      mem_wa;
    logic [WORD_W-1:0]  mem_wd;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  masked;
    logic [BIT_W-1:0]   idx;
    logic               hit;
    logic [WA+BIT_W-1:0] pos;

    // shift split of the latched value
    assign ws    = XW'(r_val >> BIT_W);
    assign bs    = r_val[BIT_W-1:0];
    assign top_x = XW'(r_top);
    assign lim_x = XW'(r_lim);
    assign d_x   = XW'(r_d);

    // highest word the add can touch
    assign grow        = top_x + ws + XW'(1);
    assign new_top     = (grow > LAST_W) ? WA'(LAST_W) : WA'(grow);
    assign prime_idx_x = XW'(new_top) - ws;
    assign lo_idx_x    = d_x - ws - XW'(1);
    assign cur_word_x  = XW'(r_cursor[CW-1:BIT_W]);

    // read addresses and zero masks for words past the old top
    always_comb begin
        a0    = r_d;
        a1    = WA'(lo_idx_x);
        n_ok0 = (d_x <= lim_x);
        n_ok1 = (d_x > ws) && (lo_idx_x <= lim_x);
        if (i_cmd.add_prime) begin
            a1    = WA'(prime_idx_x);
            n_ok1 = (prime_idx_x <= top_x);
        end
        if (i_cmd.fetch_start) begin
            a0 = WA'(cur_word_x);
        end else if (i_cmd.fetch_step) begin
            a0 = r_rd_word + WA'(1);
        end
    end

    // shift-or of one word
    assign m0        = r_ok0 ? r_rd0 : '0;
    assign m1        = r_ok1 ? r_rd1 : '0;
    assign carry_in  = (bs != '0) ? (m1 >> (7'(WORD_W) - {1'b0, bs})) : '0;
    assign add_wdata = m0 | (r_src_hi << bs) | carry_in;

    assign mem_we = i_cmd.clear || r_pend;
    assign mem_wa = i_cmd.clear ? '0 : r_wd;
    assign mem_wd = i_cmd.clear ? WORD_W'(1) : add_wdata;

    // memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd0 <= mem[a0];
        r_rd1 <= mem[a1];
    end

    // first set bit at or above the cursor in the fetched word
    assign lo_mask = r_first ? ({WORD_W{1'b1}} << r_off) : {WORD_W{1'b1}};
    assign masked  = r_rd0 & lo_mask;
    assign hit     = (masked != '0);

    always_comb begin
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (masked[i]) begin
                idx = BIT_W'(i);
            end
        end
    end

    assign pos = {r_rd_word, idx};

    // status to the controller
    always_comb begin
        o_stat           = '0;
        o_stat.full      = (r_count >= NW'(MAX_ITEMS));
        o_stat.ws_out    = (ws >= XW'(MAP_WORDS));
        o_stat.d_zero    = (r_d == '0);
        o_stat.cur_out   = (cur_word_x > top_x);
        o_stat.hit       = hit;
        o_stat.scan_last = (r_rd_word >= r_top);
        o_stat.out_free  = !r_o_vld || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_top    <= '0;
            r_pend   <= 1'b0;
            r_prime  <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_pend  <= i_cmd.add_step;
            r_prime <= i_cmd.add_prime;
            if (i_cmd.clear) begin
                r_count  <= '0;
                r_cursor <= '0;
                r_top    <= '0;
            end
            if (i_cmd.add_noop || i_cmd.add_prime) begin
                r_count  <= r_count + NW'(1);
                r_cursor <= '0;
            end
            if (i_cmd.add_prime) begin
                r_top <= new_top;
            end
            if (i_cmd.fetch_step && hit) begin
                r_cursor <= CW'(pos) + CW'(1);
            end
            if (i_cmd.put) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_val <= i_value & VAL_MASK;
        end
        if (i_cmd.add_prime) begin
            r_lim <= r_top;
            r_d   <= new_top;
        end
        if (i_cmd.add_step) begin
            r_wd <= r_d;
            r_d  <= r_d - WA'(1);
        end
        r_ok0 <= n_ok0;
        r_ok1 <= n_ok1;
        if (r_prime || r_pend) begin
            r_src_hi <= m1;
        end
        if (i_cmd.fetch_start) begin
            r_rd_word <= WA'(cur_word_x);
            r_off     <= r_cursor[BIT_W-1:0];
            r_first   <= 1'b1;
        end else if (i_cmd.fetch_step) begin
            r_rd_word <= r_rd_word + WA'(1);
            r_first   <= 1'b0;
        end
        if (i_cmd.res_ok || i_cmd.res_rej) begin
            r_res_sum <= '0;
            r_res_sv  <= 1'b0;
            r_res_acc <= i_cmd.res_ok;
        end else if (i_cmd.fetch_step) begin
            r_res_sum <= hit ? SUM_W'(pos) : '0;
            r_res_sv  <= hit;
            r_res_acc <= 1'b1;
        end
        if (i_cmd.put) begin
            r_o_sum <= r_res_sum;
            r_o_sv  <= r_res_sv;
            r_o_acc <= r_res_acc;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_sum       = r_o_sum;
    assign o_sum_valid = r_o_sv;
    assign o_accepted  = r_o_acc;

    // add writes stay within the grown map
    a_write_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_wd <= r_top))
        else $error("bitmap write above top word");

    // item count never passes the limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_ITEMS))
        else $error("item count over limit");

    // a response is loaded only into a free output register
    a_put_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |-> o_stat.out_free)
        else $error("output register overwritten");

    // fetch scan never examines a word past the top used word
    a_scan_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch_step |-> (r_rd_word <= r_top))
        else $error("fetch scan past top word");

endmodule

`default_nettype wire

[rtl/core/subset_sum_set.sv]
// subset_sum_set: reachable subset sums kept as a bitmap of 64-bit words in one RAM
// to S_PUT: clear via S_CLEAR, unknown code direct, refused or off-map add via S_ADD_CHK,
// add via S_ADD_RUN (new top word down to 0) and S_ADD_DRAIN, fetch via S_FETCH_RD/_SCAN
// throughput: one request at a time; an add rewrites one bitmap word per cycle on the single
// write port, a fetch scans one word per cycle; a new request is taken while a response waits
// reset: synchronous, active low; after release S_INIT seeds word 0 before ready rises
`timescale 1ns / 1ps
`default_nettype none

module subset_sum_set #(
    parameter int MAX_ITEMS  = 16,
    parameter int VALUE_BITS = 8,
    parameter int MAP_WORDS  = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sss_req_if.sink    i_req,
    sss_rsp_if.source  o_rsp
);
    import sss_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    sss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_command   (i_req.command),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // bitmap memory, counters and response register
    sss_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS),
        .MAP_WORDS  (MAP_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_req.value),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_sum       (o_rsp.sum),
        .o_sum_valid (o_rsp.sum_valid),
        .o_accepted  (o_rsp.accepted)
    );

endmodule

`default_nettype wire
